// ----- rtl/tvsi_pkg.sv -----
package tvsi_pkg;

    // request action codes
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_SLICE  = 2'd2;
    localparam logic [1:0] ACT_INDEX  = 2'd3;

    // result status codes
    localparam logic [2:0] STS_OK   = 3'd0;
    localparam logic [2:0] STS_OOB  = 3'd1;
    localparam logic [2:0] STS_AXIS = 3'd2;
    localparam logic [2:0] STS_FULL = 3'd3;
    localparam logic [2:0] STS_OVF  = 3'd4;

    // shared unit operations
    localparam logic ALU_MUL = 1'b0;
    localparam logic ALU_DIV = 1'b1;

    // operand widths of the shared unit
    localparam int ALU_AW = 48;
    localparam int ALU_BW = 32;

    typedef struct packed {
        logic              start;
        logic              op;
        logic [ALU_AW-1:0] a;
        logic [ALU_BW-1:0] b;
    } t_alu_req;

    // res holds the 80-bit product, or the quotient in its upper 48 bits
    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic [ALU_AW+ALU_BW-1:0] res;
    } t_alu_rsp;

endpackage

// ----- rtl/tvsi_alu.sv -----
module tvsi_alu import tvsi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic              r_op;
    logic [5:0]        r_cnt;
    logic [ALU_AW-1:0] r_a;
    logic [ALU_BW-1:0] r_b;
    logic [ALU_AW-1:0] r_hi;
    logic [ALU_BW-1:0] r_lo;

    logic [ALU_AW:0]   add_sum;
    logic [ALU_BW:0]   trial;
    logic [ALU_BW:0]   rem_sub;
    logic              fits;
    logic              last;

    // shift-add multiply step and restoring divide step
    always_comb begin
        add_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(ALU_AW+1){1'b0}});
        trial   = {r_lo, r_hi[ALU_AW-1]};
        rem_sub = trial - {1'b0, r_b};
        fits    = (trial >= {1'b0, r_b});
        last    = (r_op == ALU_MUL) ? (r_cnt == 6'(ALU_BW - 1)) : (r_cnt == 6'(ALU_AW - 1));
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op <= i_req.op;
            r_a  <= i_req.a;
            r_b  <= i_req.b;
            r_hi <= (i_req.op == ALU_MUL) ? {ALU_AW{1'b0}} : i_req.a;
            r_lo <= (i_req.op == ALU_MUL) ? i_req.b : {ALU_BW{1'b0}};
        end else if (r_busy) begin
            if (r_op == ALU_MUL) begin
                r_hi <= add_sum[ALU_AW:1];
                r_lo <= {add_sum[0], r_lo[ALU_BW-1:1]};
            end else begin
                r_hi <= {r_hi[ALU_AW-2:0], fits};
                r_lo <= fits ? rem_sub[ALU_BW-1:0] : trial[ALU_BW-1:0];
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.res  = {r_hi, r_lo};

endmodule

// ----- rtl/tensor_view_slice_index.sv -----
// sequence: clear or rejected request goes from check to result; append one multiply;
//   index a multiply, a divide, a shift of higher axes; slice two 48-step divides and
//   three 32-step multiplies (an empty slice or a zero-extent axis skips a divide)
// throughput: one request at a time, the next accepted in the cycle after the result is
//   registered; all products and quotients go through one shift-add / restoring-divide
//   unit taking one bit per cycle; a stalled result holds the sequencer in its last state
// reset: synchronous, active low; empty view (rank 0, offset 0, count 1), element bytes 4
module tensor_view_slice_index import tvsi_pkg::*; #(
    parameter int MAX_DIMS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [2:0]         i_axis,
    input  logic [31:0]        i_new_size,
    input  logic signed [47:0] i_new_stride,
    input  logic [31:0]        i_slice_start,
    input  logic signed [32:0] i_slice_stop,
    input  logic signed [31:0] i_slice_step,
    input  logic signed [32:0] i_pick,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic [3:0]         o_rank_out,
    output logic signed [47:0] o_offset_out,
    output logic [47:0]        o_element_total,
    output logic [51:0]        o_byte_total,
    output logic [31:0]        o_axis_size_out,
    output logic signed [47:0] o_axis_stride_out
);

    localparam int IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int RW = $clog2(MAX_DIMS + 1);
    localparam logic [1:0] REG_ELEMENT_BYTES = 2'd0;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_APMUL  = 4'd2;
    localparam logic [3:0] S_SZDIV  = 4'd3;
    localparam logic [3:0] S_CNTDIV = 4'd4;
    localparam logic [3:0] S_CNTMUL = 4'd5;
    localparam logic [3:0] S_OFFMUL = 4'd6;
    localparam logic [3:0] S_STRMUL = 4'd7;
    localparam logic [3:0] S_SHIFT  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]  r_state;
    logic        r_run;
    logic [1:0]  r_act;
    logic [2:0]  r_axis;
    logic [RW-1:0] r_ptr;
    logic [31:0] r_new_size;
    logic [47:0] r_new_stride;
    logic [31:0] r_start;
    logic [32:0] r_stop;
    logic [31:0] r_step;
    logic [32:0] r_pick;
    logic [31:0] r_old;
    logic [47:0] r_stride;
    logic [31:0] r_pos;
    logic [31:0] r_diff;
    logic [31:0] r_divsr;
    logic        r_nonempty;
    logic [2:0]  r_status;
    logic [31:0] r_nsz;
    logic [47:0] r_nstride;
    logic [47:0] r_noff;
    logic [47:0] r_ncount;
    logic [47:0] r_q;

    logic [31:0] r_sizes   [MAX_DIMS];
    logic [47:0] r_strides [MAX_DIMS];
    logic [RW-1:0] r_rank;
    logic [47:0] r_offset;
    logic [47:0] r_count;
    logic [4:0]  r_ebytes;

    logic        r_out_valid;
    logic [2:0]  r_o_status;
    logic [3:0]  r_o_rank;
    logic [47:0] r_o_offset;
    logic [47:0] r_o_count;
    logic [51:0] r_o_bytes;
    logic [31:0] r_o_size;
    logic [47:0] r_o_stride;

    t_alu_req    alu_req;
    t_alu_rsp    alu_rsp;
    logic [47:0] quot;
    logic        prod_ovf;
    logic        alu_done;

    logic          in_accept;
    logic          out_free;
    logic [IW-1:0] rd_idx;
    logic [RW:0]   ptr_next;
    logic          shift_more;
    logic [31:0]   rd_size;
    logic [47:0]   rd_stride;

    logic signed [33:0] start34;
    logic signed [33:0] stop34;
    logic signed [33:0] pick34;
    logic signed [33:0] sz34;
    logic signed [33:0] fwd_diff;
    logic signed [33:0] bwd_diff;
    logic signed [33:0] pick_wrap;
    logic        fwd;
    logic        bwd;
    logic        oob;
    logic        axis_bad;
    logic        rank_full;
    logic [32:0] nsz_inc;

    logic          ok;
    logic [RW-1:0] new_rank;
    logic [47:0]   out_off;
    logic [47:0]   out_cnt;
    logic [52:0]   bytes_prod;
    logic          axis_out;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_ELEMENT_BYTES) ? {27'd0, r_ebytes} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ebytes <= 5'd4;
        end else if (psel && penable && pwrite && pready && paddr == REG_ELEMENT_BYTES) begin
            r_ebytes <= pwdata[4:0];
        end
    end

    // handshakes
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // single axis read port: requested axis when idle, next higher axis while shifting
    assign ptr_next   = {1'b0, r_ptr} + 1'b1;
    assign shift_more = (ptr_next < {1'b0, r_rank});
    assign rd_idx     = (r_state == S_IDLE) ? IW'(i_axis) : IW'(ptr_next);
    assign rd_size    = r_sizes[rd_idx];
    assign rd_stride  = r_strides[rd_idx];

    // request checks and slice extent operands
    always_comb begin
        start34   = $signed({2'b00, r_start});
        stop34    = $signed({r_stop[32], r_stop});
        pick34    = $signed({r_pick[32], r_pick});
        sz34      = $signed({2'b00, r_old});
        fwd       = (start34 < stop34) && !r_step[31] && (r_step != 32'd0);
        bwd       = (start34 > stop34) && r_step[31];
        fwd_diff  = stop34 - start34 - 34'sd1;
        bwd_diff  = start34 - stop34 - 34'sd1;
        oob       = (pick34 >= sz34) || (pick34 < -sz34);
        pick_wrap = pick34[33] ? (pick34 + sz34) : pick34;
        axis_bad  = (32'(r_axis) >= 32'(r_rank));
        rank_full = (32'(r_rank) >= 32'(MAX_DIMS));
    end

    // shared unit requests
    always_comb begin
        alu_req.start = 1'b0;
        alu_req.op    = ALU_MUL;
        alu_req.a     = 48'd0;
        alu_req.b     = 32'd0;
        case (r_state)
            S_APMUL: begin
                alu_req.start = !r_run;
                alu_req.a     = r_count;
                alu_req.b     = r_new_size;
            end
            S_SZDIV: begin
                alu_req.start = !r_run && r_nonempty;
                alu_req.op    = ALU_DIV;
                alu_req.a     = {16'd0, r_diff};
                alu_req.b     = r_divsr;
            end
            S_CNTDIV: begin
                alu_req.start = !r_run && (r_old != 32'd0);
                alu_req.op    = ALU_DIV;
                alu_req.a     = r_count;
                alu_req.b     = r_old;
            end
            S_CNTMUL: begin
                alu_req.start = !r_run;
                alu_req.a     = r_q;
                alu_req.b     = r_nsz;
            end
            S_OFFMUL: begin
                alu_req.start = !r_run;
                alu_req.a     = r_stride;
                alu_req.b     = r_pos;
            end
            S_STRMUL: begin
                alu_req.start = !r_run;
                alu_req.a     = r_stride;
                alu_req.b     = r_step;
            end
            default: begin
                alu_req.start = 1'b0;
            end
        endcase
    end

    tvsi_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .o_rsp   (alu_rsp)
    );

    assign quot     = alu_rsp.res[79:32];
    assign prod_ovf = (alu_rsp.res[79:48] != 32'd0);
    assign alu_done = r_run && alu_rsp.done;
    assign nsz_inc  = {1'b0, quot[31:0]} + 33'd1;

    // view after the request
    always_comb begin
        ok = (r_status == STS_OK);
        new_rank = r_rank;
        if (ok) begin
            case (r_act)
                ACT_CLEAR:  new_rank = '0;
                ACT_APPEND: new_rank = r_rank + 1'b1;
                ACT_INDEX:  new_rank = r_rank - 1'b1;
                default:    new_rank = r_rank;
            endcase
        end
        out_off    = ok ? r_noff : r_offset;
        out_cnt    = ok ? r_ncount : r_count;
        bytes_prod = 53'(out_cnt) * 53'(r_ebytes);
        axis_out   = ok && (r_act == ACT_APPEND || r_act == ACT_SLICE);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_run    <= 1'b0;
            r_rank   <= '0;
            r_offset <= 48'd0;
            r_count  <= 48'd1;
        end else begin
            if (alu_req.start) begin
                r_run <= 1'b1;
            end else if (alu_done) begin
                r_run <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_act        <= i_action;
                        r_axis       <= i_axis;
                        r_ptr        <= RW'(i_axis);
                        r_new_size   <= i_new_size;
                        r_new_stride <= i_new_stride;
                        r_start      <= i_slice_start;
                        r_stop       <= i_slice_stop;
                        r_step       <= i_slice_step;
                        r_pick       <= i_pick;
                        r_old        <= rd_size;
                        r_stride     <= rd_stride;
                        r_state      <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_noff    <= r_offset;
                    r_ncount  <= r_count;
                    r_nsz     <= 32'd0;
                    r_nstride <= 48'd0;
                    r_status  <= STS_OK;
                    case (r_act)
                        ACT_CLEAR: begin
                            r_noff   <= 48'd0;
                            r_ncount <= 48'd1;
                            r_state  <= S_DONE;
                        end
                        ACT_APPEND: begin
                            if (rank_full) begin
                                r_status <= STS_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_APMUL;
                            end
                        end
                        ACT_SLICE: begin
                            r_pos      <= r_start;
                            r_nonempty <= fwd || bwd;
                            r_diff     <= fwd ? fwd_diff[31:0] : bwd_diff[31:0];
                            r_divsr    <= fwd ? r_step : (32'd0 - r_step);
                            if (axis_bad) begin
                                r_status <= STS_AXIS;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_SZDIV;
                            end
                        end
                        default: begin
                            r_pos <= pick_wrap[31:0];
                            if (axis_bad) begin
                                r_status <= STS_AXIS;
                                r_state  <= S_DONE;
                            end else if (oob) begin
                                r_status <= STS_OOB;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_OFFMUL;
                            end
                        end
                    endcase
                end
                S_APMUL: begin
                    if (alu_done) begin
                        if (prod_ovf) begin
                            r_status <= STS_OVF;
                        end else begin
                            r_ncount  <= alu_rsp.res[47:0];
                            r_nsz     <= r_new_size;
                            r_nstride <= r_new_stride;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_SZDIV: begin
                    if (!r_nonempty) begin
                        r_nsz   <= 32'd0;
                        r_state <= S_CNTDIV;
                    end else if (alu_done) begin
                        // extent saturates at the field maximum
                        r_nsz   <= (quot[47:32] != 16'd0 || nsz_inc[32]) ?
                                   32'hFFFF_FFFF : nsz_inc[31:0];
                        r_state <= S_CNTDIV;
                    end
                end
                S_CNTDIV: begin
                    if (r_old == 32'd0) begin
                        // empty axis keeps the count at zero
                        r_ncount <= 48'd0;
                        r_state  <= S_OFFMUL;
                    end else if (alu_done) begin
                        if (r_act == ACT_INDEX) begin
                            r_ncount <= quot;
                            r_state  <= S_SHIFT;
                        end else begin
                            r_q     <= quot;
                            r_state <= S_CNTMUL;
                        end
                    end
                end
                S_CNTMUL: begin
                    if (alu_done) begin
                        if (prod_ovf) begin
                            r_status <= STS_OVF;
                            r_state  <= S_DONE;
                        end else begin
                            r_ncount <= alu_rsp.res[47:0];
                            r_state  <= S_OFFMUL;
                        end
                    end
                end
                S_OFFMUL: begin
                    if (alu_done) begin
                        r_noff  <= r_offset + alu_rsp.res[47:0];
                        r_state <= (r_act == ACT_INDEX) ? S_CNTDIV : S_STRMUL;
                    end
                end
                S_STRMUL: begin
                    if (alu_done) begin
                        // negative step: take away stride * 2^32 modulo 2^48
                        r_nstride <= alu_rsp.res[47:0] -
                                     (r_step[31] ? {r_stride[15:0], 32'd0} : 48'd0);
                        r_state   <= S_DONE;
                    end
                end
                S_SHIFT: begin
                    if (shift_more) begin
                        r_ptr <= ptr_next[RW-1:0];
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_rank   <= new_rank;
                        r_offset <= out_off;
                        r_count  <= out_cnt;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // axis table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DIMS; i++) begin
                r_sizes[i]   <= 32'd0;
                r_strides[i] <= 48'd0;
            end
        end else if (r_state == S_SHIFT) begin
            // move higher axes down one place, zero the old top
            if (shift_more) begin
                r_sizes[r_ptr[IW-1:0]]   <= rd_size;
                r_strides[r_ptr[IW-1:0]] <= rd_stride;
            end else begin
                r_sizes[r_ptr[IW-1:0]]   <= 32'd0;
                r_strides[r_ptr[IW-1:0]] <= 48'd0;
            end
        end else if (r_state == S_DONE && out_free && ok) begin
            case (r_act)
                ACT_CLEAR: begin
                    for (int i = 0; i < MAX_DIMS; i++) begin
                        r_sizes[i]   <= 32'd0;
                        r_strides[i] <= 48'd0;
                    end
                end
                ACT_APPEND: begin
                    r_sizes[r_rank[IW-1:0]]   <= r_nsz;
                    r_strides[r_rank[IW-1:0]] <= r_nstride;
                end
                ACT_SLICE: begin
                    r_sizes[r_ptr[IW-1:0]]   <= r_nsz;
                    r_strides[r_ptr[IW-1:0]] <= r_nstride;
                end
                default: begin
                    r_sizes[0] <= r_sizes[0];
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_status <= r_status;
            r_o_rank   <= 4'(new_rank);
            r_o_offset <= out_off;
            r_o_count  <= out_cnt;
            r_o_bytes  <= bytes_prod[51:0];
            r_o_size   <= axis_out ? r_nsz : 32'd0;
            r_o_stride <= axis_out ? r_nstride : 48'd0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_o_status;
    assign o_rank_out        = r_o_rank;
    assign o_offset_out      = r_o_offset;
    assign o_element_total   = r_o_count;
    assign o_byte_total      = r_o_bytes;
    assign o_axis_size_out   = r_o_size;
    assign o_axis_stride_out = r_o_stride;

    // checks
    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_rank) <= 32'(MAX_DIMS))
        else $error("view rank beyond the axis table");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_CHECK))
        else $error("accepted request did not start the sequence");

    a_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> r_run)
        else $error("shared unit finished without an outstanding operation");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |-> !alu_rsp.busy)
        else $error("shared unit started while busy");

endmodule
